// File: rtl/potts_mean_field_argmax_sample_defines.svh
// Assertion macros for the block's top-level RTL file.
`ifndef POTTS_MEAN_FIELD_ARGMAX_SAMPLE_DEFINES_SVH
`define POTTS_MEAN_FIELD_ARGMAX_SAMPLE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define PMF_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define PMF_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pmf_pkg.sv
// Types, constants and helpers for the Potts mean-field argmax block.
package pmf_pkg;

  localparam int unsigned STATES  = 5;
  localparam int unsigned NStages = 8;
  localparam int unsigned SplitK  = 3;
  localparam int unsigned NumRegs = 8;

  localparam int unsigned DataW = 32;
  localparam int unsigned ZW    = 16;
  localparam int unsigned WinW  = 3;
  localparam int unsigned FuncW = 2;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned ProdW = 48;
  localparam int unsigned MulW  = 64;
  localparam int unsigned OvlW  = 48;
  localparam int unsigned SumW  = 35;
  localparam int unsigned DiffW = 33;
  localparam int unsigned BaseW = 49;
  localparam int unsigned HW    = 52;
  localparam int unsigned CorrW = 36;

  localparam logic [IdxW-1:0] RegMeanOverlap  = 3'd0;
  localparam logic [IdxW-1:0] RegFieldOffset  = 3'd1;
  localparam logic [IdxW-1:0] RegGainQuiet    = 3'd2;
  localparam logic [IdxW-1:0] RegGainActive   = 3'd3;
  localparam logic [IdxW-1:0] RegCoupMatch    = 3'd4;
  localparam logic [IdxW-1:0] RegCoupMismatch = 3'd5;
  localparam logic [IdxW-1:0] RegWeightQuiet  = 3'd6;
  localparam logic [IdxW-1:0] RegWeightActive = 3'd7;

  localparam logic signed [DataW-1:0] CfgReset [NumRegs] = '{
    32'sd655360, -32'sd32684, 32'sd0, 32'sd0,
    32'sd64225, -32'sd1311, 32'sd0, 32'sd0
  };

  localparam logic signed [DataW-1:0] QOne = 32'sd65536;

  typedef enum logic [FuncW-1:0] {
    FuncOverlap  = 2'd0,
    FuncActivity = 2'd1,
    FuncCorr     = 2'd2,
    FuncNone     = 2'd3
  } func_e;

  // per-stage load enables for the scaled-term unit
  typedef struct packed {
    logic prod;
    logic coup;
    logic term;
  } stage_en_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [MulW-1:0] x);
    logic signed [DataW-1:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/pmf_if.sv
// Valid/ready channel interfaces for samples and results.
interface pmf_in_if;
  import pmf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FuncW-1:0]        func;
  logic [2:0]              xi;
  logic signed [ZW-1:0]    z_0;
  logic signed [ZW-1:0]    z_1;
  logic signed [ZW-1:0]    z_2;
  logic signed [ZW-1:0]    z_3;
  logic signed [ZW-1:0]    z_4;
  logic signed [ZW-1:0]    z_5;

  modport source (output valid, func, xi, z_0, z_1, z_2, z_3, z_4, z_5, input ready);
  modport sink   (input valid, func, xi, z_0, z_1, z_2, z_3, z_4, z_5, output ready);
endinterface

interface pmf_out_if;
  import pmf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [WinW-1:0]         winner;
  logic signed [DataW-1:0] contribution;

  modport source (output valid, winner, contribution, input ready);
  modport sink   (input valid, winner, contribution, output ready);
endinterface

// File: rtl/potts_mean_field_argmax_sample.sv
// Top level: Potts mean-field argmax over one Monte Carlo sample per transfer.
//
// Input channel in_if_i carries one sample per transfer: func, pattern state
// xi and the Gaussian draws z_0..z_5. Output channel out_if_o returns one
// result per sample: the winning state and the contribution picked by func.
// Both channels transfer on a clock edge with valid and ready high.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i,
// one register per cycle; the user writes them only while no sample is in flight,
// which the block itself does not enforce. The datapath is an eight-stage
// pipeline: scaled terms (three stages: gain product, coupling product, shift and
// saturate), field sums, field totals, a two-stage argmax and the result
// register. Throughput is one sample per cycle while the receiver is ready.
// Reset clears every stage valid bit and loads the configuration defaults.
// When the receiver stalls, the result register holds; each stage keeps
// loading while the one after it is empty or moving, so bubbles close up and
// in_if_i.ready drops only once all eight stages hold samples.
module potts_mean_field_argmax_sample (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pmf_pkg::IdxW-1:0]         cfg_idx_i,
  input  logic [pmf_pkg::DataW-1:0]        cfg_data_i,
  pmf_in_if.sink                           in_if_i,
  pmf_out_if.source                        out_if_o
);
  import pmf_pkg::*;
  `include "potts_mean_field_argmax_sample_defines.svh"

  // configuration
  logic signed [DataW-1:0] cfg_q [NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        cfg_q[i] <= CfgReset[i];
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  logic signed [DataW-1:0] c_match, c_mis;
  assign c_match = cfg_q[RegCoupMatch];
  assign c_mis   = cfg_q[RegCoupMismatch];

  // pipeline control
  logic [NStages-1:0] v_q, en;

  always_comb begin
    en[NStages-1] = !v_q[NStages-1] || out_if_o.ready;
    for (int s = NStages - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_if_i.valid;
      end
      for (int s = 1; s < NStages; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  assign in_if_i.ready = en[0];

  stage_en_t sc_en;
  assign sc_en = '{prod: en[0], coup: en[1], term: en[2]};

  // sideband carried along the pipe
  logic [2:0]       xi_q   [0:NStages-2];
  logic [FuncW-1:0] func_q [0:NStages-2];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      xi_q[0]   <= in_if_i.xi;
      func_q[0] <= in_if_i.func;
    end
    for (int s = 1; s < NStages - 1; s++) begin
      if (en[s]) begin
        xi_q[s]   <= xi_q[s-1];
        func_q[s] <= func_q[s-1];
      end
    end
  end

  // stages 0..2: scaled noise and correlation terms
  logic signed [ZW-1:0]    zin [0:STATES];
  assign zin[0] = in_if_i.z_0;
  assign zin[1] = in_if_i.z_1;
  assign zin[2] = in_if_i.z_2;
  assign zin[3] = in_if_i.z_3;
  assign zin[4] = in_if_i.z_4;
  assign zin[5] = in_if_i.z_5;

  logic signed [DataW-1:0] tn_mis   [0:STATES];
  logic signed [DataW-1:0] tn_match [1:STATES];
  logic signed [DataW-1:0] wn_mis   [0:STATES];
  logic signed [DataW-1:0] wn_match [1:STATES];

  // state zero always pairs with the mismatch coupling
  pmf_scale u_noise_q (
    .clk_i     (clk_i),
    .en_i      (sc_en),
    .z_i       (zin[0]),
    .gain_i    (cfg_q[RegGainQuiet]),
    .c_match_i (c_match),
    .c_mis_i   (c_mis),
    .t_match_o (),
    .t_mis_o   (tn_mis[0])
  );

  pmf_scale u_corr_q (
    .clk_i     (clk_i),
    .en_i      (sc_en),
    .z_i       (zin[0]),
    .gain_i    (cfg_q[RegWeightQuiet]),
    .c_match_i (c_match),
    .c_mis_i   (c_mis),
    .t_match_o (),
    .t_mis_o   (wn_mis[0])
  );

  for (genvar n = 1; n <= STATES; n++) begin : g_act
    pmf_scale u_noise (
      .clk_i     (clk_i),
      .en_i      (sc_en),
      .z_i       (zin[n]),
      .gain_i    (cfg_q[RegGainActive]),
      .c_match_i (c_match),
      .c_mis_i   (c_mis),
      .t_match_o (tn_match[n]),
      .t_mis_o   (tn_mis[n])
    );

    pmf_scale u_corr (
      .clk_i     (clk_i),
      .en_i      (sc_en),
      .z_i       (zin[n]),
      .gain_i    (cfg_q[RegWeightActive]),
      .c_match_i (c_match),
      .c_mis_i   (c_mis),
      .t_match_o (wn_match[n]),
      .t_mis_o   (wn_mis[n])
    );
  end

  // stages 1..2: overlap terms
  logic signed [MulW-1:0] ovp_m_q, ovp_n_q;
  logic signed [OvlW-1:0] ovl_m_q, ovl_n_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ovp_m_q <= MulW'(c_match) * MulW'(cfg_q[RegMeanOverlap]);
      ovp_n_q <= MulW'(c_mis) * MulW'(cfg_q[RegMeanOverlap]);
    end
    if (en[2]) begin
      ovl_m_q <= OvlW'(ovp_m_q >>> 16);
      ovl_n_q <= OvlW'(ovp_n_q >>> 16);
    end
  end

  // stage 3: sums over states and per-state differences
  logic signed [SumW-1:0]  msum_d, usum_d;
  logic signed [BaseW-1:0] base_d [1:STATES];
  logic signed [DiffW-1:0] d_d    [1:STATES];
  logic signed [DiffW-1:0] ud_d   [1:STATES];

  always_comb begin
    msum_d = '0;
    usum_d = '0;
    for (int n = 0; n <= STATES; n++) begin
      msum_d = msum_d + SumW'(tn_mis[n]);
      usum_d = usum_d + SumW'(wn_mis[n]);
    end
    for (int k = 1; k <= STATES; k++) begin
      base_d[k] = BaseW'((xi_q[2] == WinW'(k)) ? ovl_m_q : ovl_n_q)
                + BaseW'(cfg_q[RegFieldOffset]);
      d_d[k]    = DiffW'(tn_match[k]) - DiffW'(tn_mis[k]);
      ud_d[k]   = DiffW'(wn_match[k]) - DiffW'(wn_mis[k]);
    end
  end

  logic signed [SumW-1:0]  msum_q;
  logic signed [BaseW-1:0] base_q [1:STATES];
  logic signed [DiffW-1:0] d_q    [1:STATES];
  logic signed [SumW-1:0]  usum_q [3:6];
  logic signed [DiffW-1:0] ud_q   [3:6][1:STATES];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      msum_q    <= msum_d;
      base_q    <= base_d;
      d_q       <= d_d;
      usum_q[3] <= usum_d;
      ud_q[3]   <= ud_d;
    end
    for (int s = 4; s <= 6; s++) begin
      if (en[s]) begin
        usum_q[s] <= usum_q[s-1];
        ud_q[s]   <= ud_q[s-1];
      end
    end
  end

  // stage 4: mean fields
  logic signed [HW-1:0] h_d [1:STATES];
  logic signed [HW-1:0] h_q [1:STATES];

  always_comb begin
    for (int k = 1; k <= STATES; k++) begin
      h_d[k] = HW'(base_q[k]) + HW'(msum_q) + HW'(d_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      h_q <= h_d;
    end
  end

  // stages 5..6: argmax, later state wins ties, field 0 is zero
  logic signed [HW-1:0] best5_d, best5_q, best6_d;
  logic [WinW-1:0]      win5_d, win5_q, win6_d, win6_q;
  logic signed [HW-1:0] ht_q [SplitK+1:STATES];

  always_comb begin
    best5_d = '0;
    win5_d  = '0;
    for (int k = 1; k <= SplitK; k++) begin
      if (h_q[k] >= best5_d) begin
        best5_d = h_q[k];
        win5_d  = WinW'(k);
      end
    end
    best6_d = best5_q;
    win6_d  = win5_q;
    for (int k = SplitK + 1; k <= STATES; k++) begin
      if (ht_q[k] >= best6_d) begin
        best6_d = ht_q[k];
        win6_d  = WinW'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      best5_q <= best5_d;
      win5_q  <= win5_d;
      for (int k = SplitK + 1; k <= STATES; k++) begin
        ht_q[k] <= h_q[k];
      end
    end
    if (en[6]) begin
      win6_q <= win6_d;
    end
  end

  // stage 7: contribution and result register
  logic signed [DiffW-1:0] ud_sel;
  logic signed [CorrW-1:0] corr;
  logic signed [DataW-1:0] contrib_d, contrib_q;
  logic [WinW-1:0]         win7_q;

  always_comb begin
    ud_sel = '0;
    for (int k = 1; k <= STATES; k++) begin
      if (win6_q == WinW'(k)) begin
        ud_sel = ud_q[6][k];
      end
    end
    corr = CorrW'(usum_q[6]) + CorrW'(ud_sel);
    unique case (func_e'(func_q[6]))
      FuncOverlap: begin
        if (win6_q == '0) begin
          contrib_d = '0;
        end else begin
          contrib_d = (xi_q[6] == win6_q) ? c_match : c_mis;
        end
      end
      FuncActivity: begin
        contrib_d = (win6_q != '0) ? QOne : '0;
      end
      FuncCorr: begin
        contrib_d = (win6_q == '0) ? '0 : sat32(MulW'(corr));
      end
      FuncNone: begin
        contrib_d = '0;
      end
      default: begin
        contrib_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      win7_q    <= win6_q;
      contrib_q <= contrib_d;
    end
  end

  assign out_if_o.valid        = v_q[NStages-1];
  assign out_if_o.winner       = win7_q;
  assign out_if_o.contribution = contrib_q;

  `PMF_ASSERT_NOW(a_stall_full, !in_if_i.ready, &v_q,
                  "input stalled while a pipeline stage is empty")
  `PMF_ASSERT_NEXT(a_enter, in_if_i.valid && in_if_i.ready, v_q[0],
                   "accepted sample did not enter stage 0")
  `PMF_ASSERT_NOW(a_win_range, out_if_o.valid, out_if_o.winner <= WinW'(STATES),
                  "winner out of range")
  `PMF_ASSERT_NOW(a_quiet_zero, out_if_o.valid && (out_if_o.winner == '0),
                  out_if_o.contribution == '0,
                  "nonzero contribution with quiet winner")

endmodule

// File: rtl/pmf_scale.sv
// Three-stage scaled term: sat((c * sat((z * g) >> 12)) >> 16) for both couplings.
module pmf_scale (
  input  logic                             clk_i,
  input  pmf_pkg::stage_en_t               en_i,
  input  logic signed [pmf_pkg::ZW-1:0]    z_i,
  input  logic signed [pmf_pkg::DataW-1:0] gain_i,
  input  logic signed [pmf_pkg::DataW-1:0] c_match_i,
  input  logic signed [pmf_pkg::DataW-1:0] c_mis_i,
  output logic signed [pmf_pkg::DataW-1:0] t_match_o,
  output logic signed [pmf_pkg::DataW-1:0] t_mis_o
);
  import pmf_pkg::*;

  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [DataW-1:0] p_d;
  logic signed [MulW-1:0]  pm_q, pm_d, pn_q, pn_d;
  logic signed [DataW-1:0] tm_q, tm_d, tn_q, tn_d;

  always_comb begin
    prod_d = ProdW'(z_i) * ProdW'(gain_i);
    p_d    = sat32(MulW'(prod_q >>> 12));
    pm_d   = MulW'(c_match_i) * MulW'(p_d);
    pn_d   = MulW'(c_mis_i) * MulW'(p_d);
    tm_d   = sat32(pm_q >>> 16);
    tn_d   = sat32(pn_q >>> 16);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      prod_q <= prod_d;
    end
    if (en_i.coup) begin
      pm_q <= pm_d;
      pn_q <= pn_d;
    end
    if (en_i.term) begin
      tm_q <= tm_d;
      tn_q <= tn_d;
    end
  end

  assign t_match_o = tm_q;
  assign t_mis_o   = tn_q;

endmodule
